// ----- sv/aosa_pkg.sv -----
package aosa_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int DEF_MAX_SLOTS = 16;
  localparam int ACC_W         = 28;
  localparam int CNT_W         = 17;
  localparam int AVG_W         = 16;
  localparam int CHAN_W        = 5;
  localparam int SLOT_PORT_W   = 4;
  localparam int SLOT_ENTRIES  = 16;
  localparam int LOG2_W        = 5;
  localparam int LIST_W        = 40;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVS_LOG2   = 3'd0,
    REG_DECIM_BITS = 3'd1,
    REG_CHAN_COUNT = 3'd2,
    REG_LIST_LOW   = 3'd3,
    REG_LIST_HIGH  = 3'd4
  } cfg_reg_t;

  // effective (clamped) settings seen by the datapath
  typedef struct packed {
    logic [LOG2_W-1:0]                   log2;
    logic [LOG2_W-1:0]                   shift;
    logic [LOG2_W-1:0]                   count;
    logic [SLOT_ENTRIES-1:0][CHAN_W-1:0] chan;
  } cfg_t;

  typedef struct packed {
    logic                   average_valid;
    logic [SLOT_PORT_W-1:0] average_slot;
    logic [AVG_W-1:0]       average_value;
    logic [CHAN_W-1:0]      next_channel;
    logic                   scan_done;
  } result_t;

endpackage

// ----- sv/aosa_cfg.sv -----
module aosa_cfg
  import aosa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [LOG2_W-1:0] ovs_r, ovs_nxt;
  logic [LOG2_W-1:0] dec_r, dec_nxt;
  logic [LOG2_W-1:0] ccnt_r, ccnt_nxt;
  logic [LIST_W-1:0] list_lo_r, list_lo_nxt;
  logic [LIST_W-1:0] list_hi_r, list_hi_nxt;
  logic [LOG2_W-1:0] lg;
  logic [LOG2_W-1:0] deci;

  always_comb begin
    ovs_nxt     = ovs_r;
    dec_nxt     = dec_r;
    ccnt_nxt    = ccnt_r;
    list_lo_nxt = list_lo_r;
    list_hi_nxt = list_hi_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OVS_LOG2:   ovs_nxt     = cfg_wdata[LOG2_W-1:0];
        REG_DECIM_BITS: dec_nxt     = cfg_wdata[LOG2_W-1:0];
        REG_CHAN_COUNT: ccnt_nxt    = cfg_wdata[LOG2_W-1:0];
        REG_LIST_LOW:   list_lo_nxt = cfg_wdata[LIST_W-1:0];
        REG_LIST_HIGH:  list_hi_nxt = cfg_wdata[LIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovs_r     <= LOG2_W'(1);
      dec_r     <= '0;
      ccnt_r    <= LOG2_W'(1);
      list_lo_r <= '0;
      list_hi_r <= '0;
    end else begin
      ovs_r     <= ovs_nxt;
      dec_r     <= dec_nxt;
      ccnt_r    <= ccnt_nxt;
      list_lo_r <= list_lo_nxt;
      list_hi_r <= list_hi_nxt;
    end
  end

  always_comb begin
    if (ovs_r == '0)              lg = LOG2_W'(1);
    else if (ovs_r > LOG2_W'(16)) lg = LOG2_W'(16);
    else                          lg = ovs_r;
    deci = (dec_r > lg) ? lg : dec_r;

    cfg.log2  = lg;
    cfg.shift = lg - deci;
    if (ccnt_r == '0)                     cfg.count = LOG2_W'(1);
    else if (ccnt_r > LOG2_W'(MAX_SLOTS)) cfg.count = LOG2_W'(MAX_SLOTS);
    else                                  cfg.count = ccnt_r;
    cfg.chan = {list_hi_r, list_lo_r};
  end

endmodule

// ----- sv/aosa_core.sv -----
module aosa_core
  import aosa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  output result_t                res,
  output logic                   count_ovf
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  thresh;
  logic              fire;
  logic [ACC_W-1:0]  shifted;
  logic [AVG_W-1:0]  avg;
  logic [LOG2_W-1:0] slot_inc;
  logic              wrap;

  always_comb begin
    acc_sum = {1'b0, acc_r} + (ACC_W+1)'(sample);
    acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    cnt_inc = cnt_r + CNT_W'(1);
    thresh  = CNT_W'(1) << cfg.log2;
    fire    = (cnt_inc >= thresh);
    shifted = acc_sat >> cfg.shift;
    avg     = (|shifted[ACC_W-1:AVG_W]) ? '1 : shifted[AVG_W-1:0];
    slot_inc = LOG2_W'(slot_r) + LOG2_W'(1);
    wrap     = (slot_inc >= cfg.count);

    if (fire) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      slot_nxt = wrap ? '0 : slot_inc[SLOT_W-1:0];
    end else begin
      acc_nxt  = acc_sat;
      cnt_nxt  = cnt_inc;
      slot_nxt = slot_r;
    end

    res.average_valid = fire;
    res.average_slot  = fire ? SLOT_PORT_W'(slot_r) : '0;
    res.average_value = fire ? avg : '0;
    res.scan_done     = fire & wrap;
    res.next_channel  = cfg.chan[SLOT_PORT_W'(slot_nxt)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  // the count is cleared whenever it reaches the threshold, so bit 16 never sticks
  assign count_ovf = cnt_r[CNT_W-1];

endmodule

// ----- sv/adc_oversample_scan_averager.sv -----
// Oversampling scan averager: each accepted 12-bit sample is added to a running
// sum; after 2^oversample_log2 samples the result carries the slot average (sum
// shifted right by oversample_log2 - decimation_bits, saturated to 16 bits),
// the slot number and a scan_done flag on the last slot. Every sample yields
// exactly one result, and next_channel always names the list entry of the slot
// the following sample belongs to. Throughput is one sample per clock; a sample
// is captured in the input register when accepted, and its result is loaded into
// the output register when that register is empty or drained (accumulate/shift/
// compare in between). The input stalls only while both registers are full and
// out_ready is low. Configuration must only be written while no transaction is
// in flight.
module adc_oversample_scan_averager
  import aosa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_average_valid,
  output logic [SLOT_PORT_W-1:0] out_average_slot,
  output logic [AVG_W-1:0]       out_average_value,
  output logic [CHAN_W-1:0]      out_next_channel,
  output logic                   out_scan_done
);

  cfg_t                   cfg;
  result_t                res;
  logic                   count_ovf;
  logic                   in_valid_r, in_valid_nxt;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                res_r;
  logic                   adv;

  aosa_cfg #(.MAX_SLOTS(MAX_SLOTS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aosa_core #(.MAX_SLOTS(MAX_SLOTS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (adv),
    .sample    (smp_r),
    .res       (res),
    .count_ovf (count_ovf)
  );

  // stage moves when the output register is empty or being drained
  assign adv      = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | adv;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) in_valid_nxt = in_valid;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) smp_r <= in_sample;
    if (adv) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_average_valid = res_r.average_valid;
  assign out_average_slot  = res_r.average_slot;
  assign out_average_value = res_r.average_value;
  assign out_next_channel  = res_r.next_channel;
  assign out_scan_done     = res_r.scan_done;

  a_done_needs_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> out_average_valid)
    else $error("scan_done without an average");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_valid |-> out_average_slot == '0 && out_average_value == '0)
    else $error("average fields set on a non-average result");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("processed transaction did not reach the output register");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !count_ovf)
    else $error("sample count passed its threshold");

endmodule

// ----- dv/testbench.sv -----
module testbench
  import aosa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS    = DEF_MAX_SLOTS;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_PRELOAD = 40;
  localparam int PHASE_ITEMS  = 75;
  localparam logic [ACC_W-1:0] ACC_LIMIT = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int SEND_IDLE[4]  = '{0, 72, 0, 31};
  localparam int RECV_STALL[4] = '{0, 0, 72, 31};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_average_valid;
  logic [SLOT_PORT_W-1:0] out_average_slot;
  logic [AVG_W-1:0]       out_average_value;
  logic [CHAN_W-1:0]      out_next_channel;
  logic                   out_scan_done;

  // predictor copy of the registers and the running state
  logic [LOG2_W-1:0] ovs_reg   = 5'd1;
  logic [LOG2_W-1:0] decim_reg = '0;
  logic [LOG2_W-1:0] count_reg = 5'd1;
  logic [LIST_W-1:0] list_lo   = '0;
  logic [LIST_W-1:0] list_hi   = '0;
  logic [ACC_W-1:0]  acc_sum   = '0;
  logic [CNT_W-1:0]  smp_count = '0;
  logic [3:0]        slot_now  = '0;

  result_t predicted_averages[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  adc_oversample_scan_averager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average_valid (out_average_valid),
    .out_average_slot  (out_average_slot),
    .out_average_value (out_average_value),
    .out_next_channel  (out_next_channel),
    .out_scan_done     (out_scan_done)
  );

  always #6 clk = ~clk;

  function automatic result_t predict_average(input logic [SAMPLE_BITS-1:0] smp);
    int lg;
    int deci;
    int slots;
    int slot_next;
    logic [ACC_W:0] sum;
    logic [ACC_W-1:0] avg;
    result_t r;
    lg = (ovs_reg == 0) ? 1 : (ovs_reg > 16) ? 16 : int'(ovs_reg);
    deci = (decim_reg > lg) ? lg : int'(decim_reg);
    slots = (count_reg == 0) ? 1 : (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
    sum = acc_sum + smp;
    acc_sum = (sum > ACC_LIMIT) ? ACC_LIMIT : sum[ACC_W-1:0];
    smp_count = smp_count + 1'b1;
    r = '0;
    // fires on reaching or passing the target, so a lowered target fires at once
    if (int'(smp_count) >= (1 << lg)) begin
      avg = acc_sum >> (lg - deci);
      r.average_valid = 1'b1;
      r.average_slot = slot_now;
      r.average_value = (avg > 65535) ? 16'hFFFF : avg[AVG_W-1:0];
      acc_sum = '0;
      smp_count = '0;
      slot_next = slot_now + 1;
      if (slot_next >= slots) begin
        slot_next = 0;
        r.scan_done = 1'b1;
      end
      slot_now = slot_next[3:0];
    end
    r.next_channel = (slot_now < 8) ? list_lo[5 * slot_now +: CHAN_W]
                                    : list_hi[5 * (slot_now - 8) +: CHAN_W];
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CFG_DATA_W-1:0];
  endfunction

  // narrow register value with garbage in the unused upper data bits
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [LOG2_W-1:0] v);
    logic [CFG_DATA_W-1:0] r;
    r = rand40();
    r[LOG2_W-1:0] = v;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1, 0));
    endcase
  endfunction

  // writes every register, plus an unmapped index that must be ignored
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] ovs_d, decim_d, count_d,
                               lo_d, hi_d);
    logic [CFG_IDX_W-1:0] idx[6];
    logic [CFG_DATA_W-1:0] val[6];
    idx = '{REG_OVS_LOG2, REG_DECIM_BITS, REG_CHAN_COUNT, REG_LIST_LOW, REG_LIST_HIGH,
            REG_UNMAPPED};
    val = '{ovs_d, decim_d, count_d, lo_d, hi_d, rand40()};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      case (idx[i])
        REG_OVS_LOG2:   ovs_reg = val[i][LOG2_W-1:0];
        REG_DECIM_BITS: decim_reg = val[i][LOG2_W-1:0];
        REG_CHAN_COUNT: count_reg = val[i][LOG2_W-1:0];
        REG_LIST_LOW:   list_lo = val[i];
        REG_LIST_HIGH:  list_hi = val[i];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    predicted_averages.push_back(predict_average(smp));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_averages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    logic [SAMPLE_BITS-1:0] s[6];
    s = '{'0, '0, '1, '1, 12'd1, 12'd2};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (s[i]) offer_sample(s[i]);
    wait_drained();
  endtask

  task automatic test_clamped_settings();
    logic [SAMPLE_BITS-1:0] s[4];
    s = '{'1, '1, '0, 12'd1};
    // oversample 0 acts as 1, decimation above it gives no shift, count 0 acts as 1;
    // slot 0 entry is 31, the largest 5-bit channel number
    apply_setting(with_junk(5'd0), with_junk(5'd31), with_junk(5'd0), '1, rand40());
    foreach (s[i]) offer_sample(s[i]);
    wait_drained();
  endtask

  task automatic test_count_lowered();
    logic [CFG_DATA_W-1:0] lo, hi;
    lo = rand40();
    hi = rand40();
    apply_setting(with_junk(5'd4), with_junk(5'd4), with_junk(5'd1), lo, hi);
    repeat (5) offer_sample('1);
    wait_drained();
    apply_setting(with_junk(5'd2), with_junk(5'd4), with_junk(5'd1), lo, hi);
    offer_sample('1);
    wait_drained();
  endtask

  task automatic test_slot_past_count();
    logic [CFG_DATA_W-1:0] lo, hi;
    lo = rand40();
    hi = rand40();
    apply_setting(with_junk(5'd1), with_junk(5'd0), with_junk(5'd5), lo, hi);
    repeat (8) offer_sample(random_sample());
    wait_drained();
    apply_setting(with_junk(5'd1), with_junk(5'd0), with_junk(5'd2), lo, hi);
    repeat (2) offer_sample(random_sample());
    wait_drained();
  endtask

  task automatic test_longest_average();
    logic [CFG_DATA_W-1:0] lo, hi;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    lo = rand40();
    hi = rand40();
    // clamped to 16 with no shift; lowering the target then flushes a sum
    // that saturates the output
    apply_setting(with_junk(5'd31), with_junk(5'd31), with_junk(5'd3), lo, hi);
    repeat (LONG_PRELOAD) offer_sample('1);
    wait_drained();
    apply_setting(with_junk(5'd1), with_junk(5'd31), with_junk(5'd3), lo, hi);
    offer_sample(random_sample());
    wait_drained();
    apply_setting(with_junk(5'd16), with_junk(5'd0), with_junk(5'd3), lo, hi);
    repeat (LONG_PRELOAD) offer_sample(random_sample());
    wait_drained();
    apply_setting(with_junk(5'd5), with_junk(5'd0), with_junk(5'd3), lo, hi);
    offer_sample(random_sample());
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_setting(with_junk(5'd1), with_junk(5'd0), with_junk(5'd3), rand40(), rand40());
    hold_req <= hold_req + 1;
    repeat (80) offer_sample(random_sample());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [LOG2_W-1:0] ovs, decim;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(9))
          7, 8:    ovs = LOG2_W'($urandom_range(8, 6));
          9:       ovs = LOG2_W'($urandom_range(31, 17));
          default: ovs = LOG2_W'($urandom_range(5, 0));
        endcase
        decim = ($urandom_range(7) == 0) ? 5'd31 : LOG2_W'($urandom_range(6, 0));
        apply_setting(with_junk(ovs), with_junk(decim),
                      with_junk(LOG2_W'($urandom_range(31, 0))), rand40(), rand40());
        repeat (PHASE_ITEMS) offer_sample(random_sample());
        wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_averages.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual valid=%0d slot=%0d value=%0d",
                 $time, out_average_valid, out_average_slot, out_average_value);
        mismatch_count++;
      end else begin
        want = predicted_averages.pop_front();
        check_field("average_valid", want.average_valid, out_average_valid);
        check_field("average_slot", want.average_slot, out_average_slot);
        check_field("average_value", want.average_value, out_average_value);
        check_field("next_channel", want.next_channel, out_next_channel);
        check_field("scan_done", want.scan_done, out_scan_done);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_clamped_settings();
    test_count_lowered();
    test_slot_past_count();
    test_longest_average();
    test_output_hold();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
